>>> src/sorted_merge_union_macros.svh
// ---------------------------------------------------------------------------
// sorted_merge_union_macros.svh
// Assertion macros for the sorted merge union block.
// ---------------------------------------------------------------------------
`ifndef SORTED_MERGE_UNION_MACROS_SVH
`define SORTED_MERGE_UNION_MACROS_SVH

`ifndef SYNTH

// cond must never hold while out of reset
`define SMU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed: condition must never hold");

// ante implies cons in the same cycle
`define SMU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

// ante implies cons in the next cycle
`define SMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define SMU_ASSERT_NEVER(lbl, clk, rstn, cond)
`define SMU_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> src/smu_pkg.sv
// ---------------------------------------------------------------------------
// smu_pkg
// Shared constants and types of the sorted merge union block.
// ---------------------------------------------------------------------------
package smu_pkg;

  localparam int DEPTH   = 32;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int MAX_OUT = 2 * DEPTH;
  localparam int DW      = 32;
  localparam int LIMW    = 7;
  localparam int POSW    = 6;
  localparam int CMDW    = 2;

  localparam logic [LIMW-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [CMDW-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MERGE  = 2'd2
  } smu_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } smu_state_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic [POSW-1:0]      position;
    logic                 empty;
    logic                 last;
  } smu_res_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic done;
  } smu_ctl_t;

endpackage

>>> src/smu_ram.sv
// ---------------------------------------------------------------------------
// smu_ram
// One-write, one-read synchronous store with registered read data.
// ---------------------------------------------------------------------------
module smu_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [smu_pkg::AW-1:0] waddr,
  input  logic [smu_pkg::DW-1:0] wdata,
  input  logic [smu_pkg::AW-1:0] raddr,
  output logic [smu_pkg::DW-1:0] rdata
);
  import smu_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/smu_merge.sv
// ---------------------------------------------------------------------------
// smu_merge
// Merge sequencer: walks both store heads and picks one word per cycle while the output slot is free.
// ---------------------------------------------------------------------------
module smu_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smu_pkg::CW-1:0]        cnt_a,
  input  logic [smu_pkg::CW-1:0]        cnt_b,
  input  logic [smu_pkg::LIMW-1:0]      limit,
  input  logic                          slot_free,
  input  logic signed [smu_pkg::DW-1:0] rd_a,
  input  logic signed [smu_pkg::DW-1:0] rd_b,
  output logic [smu_pkg::AW-1:0]        raddr_a,
  output logic [smu_pkg::AW-1:0]        raddr_b,
  output smu_pkg::smu_ctl_t             ctl,
  output smu_pkg::smu_res_t             res
);
  import smu_pkg::*;

  smu_state_t      state_r, state_nxt;
  logic [CW-1:0]   ia_r, ia_nxt, ib_r, ib_nxt;
  logic [LIMW-1:0] n_r, n_nxt;

  logic            a_has, b_has, can, more;
  logic            take_a, take_b;
  logic [CW-1:0]   ia_adv, ib_adv;
  logic [LIMW-1:0] lim, n_inc;
  logic [DW-1:0]   pick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ia_r    <= '0;
      ib_r    <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      n_r     <= n_nxt;
    end
  end

  // read data always belongs to the registered head index
  assign raddr_a = ia_nxt[AW-1:0];
  assign raddr_b = ib_nxt[AW-1:0];

  always_comb begin
    lim    = (limit > LIMW'(MAX_OUT)) ? LIMW'(MAX_OUT) : limit;
    a_has  = ia_r < cnt_a;
    b_has  = ib_r < cnt_b;
    can    = (n_r < lim) && (a_has || b_has);
    take_a = 1'b0;
    take_b = 1'b0;
    if (a_has && b_has) begin
      take_a = !(rd_b < rd_a);
      take_b = !(rd_a < rd_b);
    end else if (a_has) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    pick   = take_a ? rd_a : rd_b;
    ia_adv = ia_r + CW'(take_a);
    ib_adv = ib_r + CW'(take_b);
    n_inc  = n_r + LIMW'(1);
    more   = (n_inc < lim) && ((ia_adv < cnt_a) || (ib_adv < cnt_b));

    state_nxt    = state_r;
    ia_nxt       = ia_r;
    ib_nxt       = ib_r;
    n_nxt        = n_r;
    ctl.busy     = (state_r != ST_IDLE);
    ctl.emit     = 1'b0;
    ctl.done     = 1'b0;
    res.value    = '0;
    res.position = '0;
    res.empty    = 1'b0;
    res.last     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        ia_nxt = '0;
        ib_nxt = '0;
        n_nxt  = '0;
        if (start) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (slot_free) begin
          ctl.emit = 1'b1;
          if (can) begin
            res.value    = pick;
            res.position = n_r[POSW-1:0];
            res.last     = !more;
            ia_nxt       = ia_adv;
            ib_nxt       = ib_adv;
            n_nxt        = n_inc;
          end else begin
            // nothing to merge at all
            res.empty = 1'b1;
            res.last  = 1'b1;
          end
          if (!can || !more) begin
            ctl.done  = 1'b1;
            state_nxt = ST_IDLE;
            ia_nxt    = '0;
            ib_nxt    = '0;
            n_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/sorted_merge_union.sv
// ---------------------------------------------------------------------------
// sorted_merge_union
// Sorted union of two loaded signed sequences, one merged word per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// channel  | handshake             | payload
// in       | in_valid / in_ready   | in_command, in_value
// out      | out_valid / out_ready | out_merged_value, out_position,
//          |                       | out_empty_res, out_last
// cfg      | cfg_wr_en             | cfg_wr_data (output limit)
//
// A load writes its store when taken. A merge's first word goes through the state
// register and the output word register, then one word per cycle follows while
// the output is not stalled. A merge holds the input until its last word is out.
// Reset is synchronous; no clearing pass, store contents stay until written.
// A stalled output register holds the merge sequencer in place.
// ---------------------------------------------------------------------------
`include "sorted_merge_union_macros.svh"

module sorted_merge_union (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [smu_pkg::CMDW-1:0]        in_command,
  input  logic signed [smu_pkg::DW-1:0]   in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [smu_pkg::DW-1:0]   out_merged_value,
  output logic [smu_pkg::POSW-1:0]        out_position,
  output logic                            out_empty_res,
  output logic                            out_last,
  input  logic                            cfg_wr_en,
  input  logic [smu_pkg::LIMW-1:0]        cfg_wr_data
);
  import smu_pkg::*;

  logic [LIMW-1:0] limit_r;
  logic [CW-1:0]   cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic            accept, start, we_a, we_b, slot_free;
  logic [AW-1:0]   raddr_a, raddr_b;
  logic [DW-1:0]   rd_a, rd_b;
  smu_ctl_t        ctl;
  smu_res_t        res;
  logic            out_valid_r;
  smu_res_t        out_r;

  assign in_ready = !ctl.busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    if (accept) begin
      unique case (in_command)
        CMD_LOAD_A: we_a  = cnt_a_r < CW'(DEPTH);
        CMD_LOAD_B: we_b  = cnt_b_r < CW'(DEPTH);
        CMD_MERGE:  start = 1'b1;
        default:    start = 1'b0;
      endcase
    end
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (ctl.done) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
    end else begin
      if (we_a) cnt_a_nxt = cnt_a_r + CW'(1);
      if (we_b) cnt_b_nxt = cnt_b_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
    end
  end

  smu_ram u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (in_value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  smu_ram u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (in_value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  assign slot_free = !out_valid_r || out_ready;

  smu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cnt_a     (cnt_a_r),
    .cnt_b     (cnt_b_r),
    .limit     (limit_r),
    .slot_free (slot_free),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .ctl       (ctl),
    .res       (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_r.value;
  assign out_position     = out_r.position;
  assign out_empty_res    = out_r.empty;
  assign out_last         = out_r.last;

  `SMU_ASSERT_NEVER(a_cnt_bound, clk, rst_n,
    (cnt_a_r > CW'(DEPTH)) || (cnt_b_r > CW'(DEPTH)))
  `SMU_ASSERT_IMPLIES(a_empty_word, clk, rst_n, out_valid && out_empty_res,
    out_last && (out_position == '0) && (out_merged_value == '0))
  `SMU_ASSERT_NEXT(a_done_clears, clk, rst_n, ctl.done,
    (cnt_a_r == '0) && (cnt_b_r == '0) && in_ready)
  `SMU_ASSERT_NEVER(a_emit_stalled, clk, rst_n, ctl.emit && !slot_free)

endmodule
